[src/nfc_pkg.sv]
// Shared types, codes and constants for the notification fragmenter.
// Used by the divider, datapath, controller and top level; no dependencies.
package nfc_pkg;

  localparam int MAX_PAYLOAD = 512;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam logic [9:0] MAX_COUNT = 10'(MAX_PAYLOAD);

  localparam logic [9:0] CAP_MIN   = 10'd20;
  localparam logic [9:0] CAP_MAX   = 10'd514;
  localparam logic [9:0] CAP_RESET = 10'd20;
  localparam logic [9:0] HDR_BYTES = 10'd8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  HDR_VERSION = 8'd1;

  // chunk count divider
  localparam int DIV_W     = 10;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_PULL   = 2'd1,
    FUNC_CLR_ID = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_DROPPED = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    HP_VERSION = 4'd0,
    HP_MSG_ID  = 4'd1,
    HP_INDEX   = 4'd2,
    HP_COUNT   = 4'd3,
    HP_LEN_LO  = 4'd4,
    HP_LEN_HI  = 4'd5,
    HP_CRC_LO  = 4'd6,
    HP_CRC_HI  = 4'd7,
    HP_DONE    = 4'd8
  } hdr_pos_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PULL,
    ST_SETUP,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_id;
    logic setup;
    logic pull;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_pending;
    logic load_drops;
    logic frag_now;
    logic div_done;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  // CRC-16/CCITT-FALSE over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/nfc_divider.sv]
// Restoring divider, one quotient bit per cycle, for the chunk count.
// Depends on nfc_pkg.
module nfc_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nfc_pkg::DIV_W-1:0] dividend,
  input  logic [nfc_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [nfc_pkg::DIV_W-1:0] quotient
);

  logic [nfc_pkg::DIV_W-1:0]     rem;
  logic [nfc_pkg::DIV_W-1:0]     dvs;
  logic [nfc_pkg::DIV_CNT_W-1:0] cnt;
  logic [nfc_pkg::DIV_W:0]       trial;
  logic [nfc_pkg::DIV_W:0]       diff;
  logic                          fits;

  assign trial = {rem, quotient[nfc_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nfc_pkg::DIV_CNT_W'(nfc_pkg::DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the low bits hold it
      rem      <= fits ? diff[nfc_pkg::DIV_W-1:0] : trial[nfc_pkg::DIV_W-1:0];
      quotient <= {quotient[nfc_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

[src/nfc_datapath.sv]
// Datapath: payload buffer, CRC, emission counters, header mux, output register.
// Depends on nfc_pkg and nfc_divider.
module nfc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  nfc_pkg::ctrl_cmd_t cmd,
  output nfc_pkg::dp_stat_t  stat,
  input  logic [7:0]         load_data,
  input  logic               load_last,
  input  logic               cfg_valid,
  input  logic [9:0]         cfg_data,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [7:0]         m_tdata,
  output logic [2:0]         m_tuser,
  output logic               m_tlast
);

  logic [7:0] store [nfc_pkg::MAX_PAYLOAD];
  logic [7:0] rdata;

  logic [9:0]        capacity;
  logic [9:0]        byte_count;
  logic [15:0]       running_crc;
  logic [7:0]        msg_counter;
  logic [5:0]        chunk_index;
  logic [5:0]        chunk_total;
  logic [9:0]        emit_offset;
  nfc_pkg::hdr_pos_t header_position;
  logic              emit_pending;
  logic              overflow_flag;
  logic              discarding;
  logic              fragmented;
  logic [9:0]        chunk_size;
  logic [9:0]        chunk_end;

  logic [9:0]  cap;
  logic        frag_now;
  logic [10:0] dividend_sum;
  logic [9:0]  quotient;
  logic        div_busy;
  logic        div_done;
  logic        store_we;
  logic        load_drops;
  logic        do_clear;

  logic [9:0]     eo_inc;
  logic           at_msg_end;
  logic           at_chunk_end;
  logic [7:0]     p_byte;
  nfc_pkg::stat_t p_stat;
  logic           p_fe;
  logic           p_me;
  logic           p_hdr;

  always_comb begin
    if (capacity < nfc_pkg::CAP_MIN) begin
      cap = nfc_pkg::CAP_MIN;
    end else if (capacity > nfc_pkg::CAP_MAX) begin
      cap = nfc_pkg::CAP_MAX;
    end else begin
      cap = capacity;
    end
  end

  assign frag_now     = byte_count > cap;
  // ceil(len / (cap - 8)) as floor((len + cap - 9) / (cap - 8))
  assign dividend_sum = 11'(byte_count) + 11'(cap) - 11'd9;

  nfc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.setup && frag_now),
    .dividend (dividend_sum[9:0]),
    .divisor  (cap - nfc_pkg::HDR_BYTES),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign load_drops = discarding || (byte_count == nfc_pkg::MAX_COUNT);
  assign store_we   = cmd.load && !discarding && (byte_count < nfc_pkg::MAX_COUNT);

  assign eo_inc       = emit_offset + 10'd1;
  assign at_msg_end   = eo_inc >= byte_count;
  assign at_chunk_end = eo_inc >= chunk_end;

  always_comb begin
    p_byte = 8'd0;
    p_stat = nfc_pkg::STAT_OK;
    p_fe   = 1'b0;
    p_me   = 1'b0;
    p_hdr  = 1'b0;
    if (!emit_pending) begin
      p_stat = overflow_flag ? nfc_pkg::STAT_DROPPED : nfc_pkg::STAT_EMPTY;
    end else if (!fragmented) begin
      p_byte = rdata;
      p_fe   = at_msg_end;
      p_me   = at_msg_end;
    end else if (header_position != nfc_pkg::HP_DONE) begin
      p_hdr = 1'b1;
      unique case (header_position)
        nfc_pkg::HP_VERSION: p_byte = nfc_pkg::HDR_VERSION;
        nfc_pkg::HP_MSG_ID:  p_byte = msg_counter;
        nfc_pkg::HP_INDEX:   p_byte = {2'b00, chunk_index};
        nfc_pkg::HP_COUNT:   p_byte = {2'b00, chunk_total};
        nfc_pkg::HP_LEN_LO:  p_byte = byte_count[7:0];
        nfc_pkg::HP_LEN_HI:  p_byte = {6'd0, byte_count[9:8]};
        nfc_pkg::HP_CRC_LO:  p_byte = running_crc[7:0];
        nfc_pkg::HP_CRC_HI:  p_byte = running_crc[15:8];
        default:             p_byte = 8'd0;
      endcase
    end else begin
      p_byte = rdata;
      p_fe   = at_chunk_end || at_msg_end;
      p_me   = at_msg_end;
    end
  end

  assign do_clear = (cmd.load && load_last && load_drops) || (cmd.pull && p_me);

  // buffer: one write port for loads, one registered read at the emit offset
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[byte_count[nfc_pkg::ADDR_W-1:0]] <= load_data;
    end
    rdata <= store[emit_offset[nfc_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.pull) begin
      m_tdata <= p_byte;
      m_tuser <= {p_me, p_stat};
      m_tlast <= p_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= nfc_pkg::CAP_RESET;
      byte_count      <= '0;
      running_crc     <= nfc_pkg::CRC_INIT;
      msg_counter     <= '0;
      chunk_index     <= '0;
      chunk_total     <= '0;
      emit_offset     <= '0;
      header_position <= nfc_pkg::HP_VERSION;
      emit_pending    <= 1'b0;
      overflow_flag   <= 1'b0;
      discarding      <= 1'b0;
      fragmented      <= 1'b0;
      chunk_size      <= '0;
      chunk_end       <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.clr_id) begin
        msg_counter <= '0;
      end

      if (cmd.load) begin
        if (store_we) begin
          if (byte_count == '0) begin
            overflow_flag <= 1'b0;
          end
          running_crc <= nfc_pkg::crc_byte(running_crc, load_data);
          byte_count  <= byte_count + 10'd1;
        end else if (!discarding) begin
          discarding <= 1'b1;
        end
        if (load_last && load_drops) begin
          overflow_flag <= 1'b1;
        end
      end

      if (cmd.setup) begin
        emit_offset     <= '0;
        chunk_index     <= '0;
        header_position <= nfc_pkg::HP_VERSION;
        emit_pending    <= 1'b1;
        fragmented      <= frag_now;
        chunk_size      <= frag_now ? cap - nfc_pkg::HDR_BYTES : cap;
        chunk_end       <= frag_now ? cap - nfc_pkg::HDR_BYTES : cap;
        chunk_total     <= 6'd1;
      end
      if (div_done) begin
        chunk_total <= quotient[5:0];
      end

      if (cmd.pull) begin
        m_tvalid <= 1'b1;
        if (p_hdr) begin
          header_position <= nfc_pkg::hdr_pos_t'(header_position + 4'd1);
        end else if (emit_pending) begin
          emit_offset <= eo_inc;
          if (fragmented && p_fe) begin
            header_position <= nfc_pkg::HP_VERSION;
            chunk_index     <= chunk_index + 6'd1;
            chunk_end       <= chunk_end + chunk_size;
            if (p_me) begin
              msg_counter <= msg_counter + 8'd1;
            end
          end
        end
      end

      // drop of an oversized payload or end of message: start an empty load
      if (do_clear) begin
        byte_count      <= '0;
        running_crc     <= nfc_pkg::CRC_INIT;
        emit_offset     <= '0;
        chunk_index     <= '0;
        chunk_total     <= '0;
        header_position <= nfc_pkg::HP_VERSION;
        emit_pending    <= 1'b0;
        discarding      <= 1'b0;
        fragmented      <= 1'b0;
        chunk_size      <= '0;
        chunk_end       <= '0;
      end
    end
  end

  assign stat.emit_pending = emit_pending;
  assign stat.load_drops   = load_drops;
  assign stat.frag_now     = frag_now;
  assign stat.div_done     = div_done;
  assign stat.div_busy     = div_busy;
  assign stat.out_free     = !m_tvalid || m_tready;

endmodule

[src/nfc_ctrl.sv]
// Controller: input handshake, command decode and sequencing of setup,
// chunk count division and pulls. Depends on nfc_pkg.
module nfc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  nfc_pkg::func_t     func,
  input  logic               load_last,
  input  nfc_pkg::dp_stat_t  stat,
  output nfc_pkg::ctrl_cmd_t cmd
);

  nfc_pkg::state_t state;
  nfc_pkg::state_t state_next;
  logic            accept;

  assign s_tready = (state == nfc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      nfc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func)
            nfc_pkg::FUNC_LOAD: begin
              // loads during emission are ignored
              cmd.load = !stat.emit_pending;
              if (!stat.emit_pending && load_last && !stat.load_drops) begin
                state_next = nfc_pkg::ST_SETUP;
              end
            end
            nfc_pkg::FUNC_PULL:   state_next = nfc_pkg::ST_PULL;
            nfc_pkg::FUNC_CLR_ID: cmd.clr_id = 1'b1;
            nfc_pkg::FUNC_NOP:    state_next = nfc_pkg::ST_IDLE;
          endcase
        end
      end
      nfc_pkg::ST_PULL: begin
        // buffer read data is valid here; wait for room in the output register
        if (stat.out_free) begin
          cmd.pull   = 1'b1;
          state_next = nfc_pkg::ST_IDLE;
        end
      end
      nfc_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = stat.frag_now ? nfc_pkg::ST_DIV : nfc_pkg::ST_IDLE;
      end
      nfc_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = nfc_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

[src/notify_fragmenter_crc16_unit.sv]
// Payload fragmenter with CRC-16/CCITT-FALSE. A pull beat is accepted, then the
// buffer read moves into the output register once that register has room.
// After the final load beat the controller runs a setup step, then waits for the
// bit-serial chunk count divider when the payload is fragmented. Reset is
// synchronous and clears all control state; the payload buffer is not cleared
// and is read only where written.
module notify_fragmenter_crc16_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_data,   // notify_capacity
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // data_byte
  input  logic [1:0] s_tuser,    // func
  input  logic       s_tlast,    // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // out_byte
  output logic [2:0] m_tuser,    // status[1:0], message_end[2]
  output logic       m_tlast     // frame_end
);

  nfc_pkg::ctrl_cmd_t cmd;
  nfc_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  nfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .func      (nfc_pkg::func_t'(s_tuser)),
    .load_last (s_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .load_data (s_tdata),
    .load_last (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !s_tready)
    else $error("input accepted while chunk count is computed");

  a_pull_result: assert property (@(posedge clk) disable iff (rst)
    cmd.pull |=> m_tvalid)
    else $error("pull gave no result beat");

  a_msg_end_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("message end without frame end");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] != nfc_pkg::STAT_OK)) |->
      (m_tdata == 8'd0 && !m_tlast && !m_tuser[2]))
    else $error("status beat carries data or end marks");

endmodule
